// ===== rtl/dzhp_pkg.sv =====
// Shared types and constants for the dictzip header parser.
// No dependencies; compiled before every other file of the block.
`default_nettype none

package dzhp_pkg;

  // Default width of the byte counter and of the absolute offsets
  localparam int OFFSET_BITS_DEF = 32;

  // Result queue depth; two slots are kept free for the worst-case byte
  localparam int RQ_DEPTH = 4;

  // gzip / dictzip header constants
  localparam logic [7:0] GZ_ID1      = 8'h1f;
  localparam logic [7:0] GZ_ID2      = 8'h8b;
  localparam logic [7:0] GZ_CM_DEFL  = 8'd8;
  localparam logic [7:0] RA_SI1      = 8'h52;
  localparam logic [7:0] RA_SI2      = 8'h41;
  localparam logic [15:0] RA_VERSION = 16'd1;
  localparam logic [15:0] RA_HDR_LEN = 16'd4;
  localparam logic [3:0] FIXED_LEN   = 4'd12;
  localparam int FLG_HCRC  = 1;
  localparam int FLG_EXTRA = 2;
  localparam int FLG_NAME  = 3;
  localparam int FLG_COMM  = 4;

  // Header byte positions inside the fixed part
  localparam logic [3:0] POS_ID1   = 4'd0;
  localparam logic [3:0] POS_ID2   = 4'd1;
  localparam logic [3:0] POS_CM    = 4'd2;
  localparam logic [3:0] POS_FLG   = 4'd3;
  localparam logic [3:0] POS_XLEN0 = 4'd10;
  localparam logic [3:0] POS_XLEN1 = 4'd11;

  // Byte offsets inside the RA subfield header
  localparam logic [3:0] SUB_SI1  = 4'd0;
  localparam logic [3:0] SUB_SI2  = 4'd1;
  localparam logic [3:0] SUB_LEN  = 4'd3;
  localparam logic [3:0] SUB_VER  = 4'd5;
  localparam logic [3:0] SUB_CLEN = 4'd7;
  localparam logic [3:0] SUB_CCNT = 4'd9;

  // Summary status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOT_DZ = 2'd1;
  localparam logic [1:0] ST_BAD    = 2'd2;

  typedef enum logic [9:0] {
    PH_FIXED   = 10'b00_0000_0001,
    PH_SUB     = 10'b00_0000_0010,
    PH_TABLE   = 10'b00_0000_0100,
    PH_SKIP    = 10'b00_0000_1000,
    PH_NAME    = 10'b00_0001_0000,
    PH_COMMENT = 10'b00_0010_0000,
    PH_CRC1    = 10'b00_0100_0000,
    PH_CRC2    = 10'b00_1000_0000,
    PH_DATA    = 10'b01_0000_0000,
    PH_FAILED  = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    logic        is_summary;
    logic [15:0] chunk_index;
    logic [31:0] chunk_start;
    logic [1:0]  status;
    logic [31:0] data_begin;
    logic [15:0] chunk_span;
    logic [15:0] chunk_total;
    logic [31:0] end_offset;
  } res_t;

  // Phase that follows a finished header section, given the gzip flags
  function automatic phase_t leave_next(phase_t done, logic [7:0] flags);
    phase_t nx;
    nx = PH_DATA;
    case (done)
      PH_SKIP: begin
        if (flags[FLG_NAME]) nx = PH_NAME;
        else if (flags[FLG_COMM]) nx = PH_COMMENT;
        else if (flags[FLG_HCRC]) nx = PH_CRC1;
      end
      PH_NAME: begin
        if (flags[FLG_COMM]) nx = PH_COMMENT;
        else if (flags[FLG_HCRC]) nx = PH_CRC1;
      end
      PH_COMMENT: begin
        if (flags[FLG_HCRC]) nx = PH_CRC1;
      end
      default: nx = PH_DATA;
    endcase
    return nx;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dzhp_in_if.sv =====
// Input channel of the dictzip header parser: one file byte per transaction.
// Depends on nothing.
`default_nettype none

interface dzhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       last_byte;

  modport source (output valid, output file_byte, output last_byte, input ready);
  modport sink   (input valid, input file_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/dzhp_out_if.sv =====
// Result channel of the dictzip header parser: chunk entries and summaries.
// Depends on nothing.
`default_nettype none

interface dzhp_out_if;
  logic        valid;
  logic        ready;
  logic        is_summary;
  logic [15:0] chunk_index;
  logic [31:0] chunk_start;
  logic [1:0]  status;
  logic [31:0] data_begin;
  logic [15:0] chunk_span;
  logic [15:0] chunk_total;
  logic [31:0] end_offset;

  modport source (output valid, output is_summary, output chunk_index, output chunk_start,
                  output status, output data_begin, output chunk_span,
                  output chunk_total, output end_offset, input ready);
  modport sink   (input valid, input is_summary, input chunk_index, input chunk_start,
                  input status, input data_begin, input chunk_span,
                  input chunk_total, input end_offset, output ready);
endinterface

`default_nettype wire

// ===== rtl/dictzip_header_parser_top.sv =====
// Dictzip header parser top level: byte-wise header walk and result queue.
// Depends on dzhp_pkg, dzhp_in_if and dzhp_out_if.
`default_nettype none

// Accepts one file byte per clock cycle. Each byte is parsed in the cycle it is
// accepted and its results are written to a four-entry result queue, from which
// out_ch offers them in order. Every word of the chunk table gives one chunk
// entry; the final byte gives a summary, and a final byte that completes a
// table word gives both. Input ready stays high while the queue has two free
// slots, so with a sink that takes a result every cycle the block sustains one
// byte per cycle; otherwise the rate follows the sink. After the summary all
// state returns to reset values and the next file may start with the next byte.
module dictzip_header_parser_top
  import dzhp_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst,
  dzhp_in_if.sink     in_ch,
  dzhp_out_if.source  out_ch
);

  localparam int CW    = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;
  localparam int PTR_W = $clog2(RQ_DEPTH);
  localparam int CNT_W = $clog2(RQ_DEPTH + 1);

  // Parser state
  logic [OFFSET_BITS-1:0] byte_position, byte_position_next;
  logic [OFFSET_BITS-1:0] data_count, data_count_next;
  phase_t                 phase, phase_next;
  logic [7:0]             header_flags, header_flags_next;
  logic [15:0]            extra_length, extra_length_next;
  logic [16:0]            extra_last, extra_last_next;
  logic [7:0]             low_byte_latch, low_byte_latch_next;
  logic [15:0]            length_per_chunk, length_per_chunk_next;
  logic [15:0]            declared_chunks, declared_chunks_next;
  logic [15:0]            chunks_seen, chunks_seen_next;
  logic [31:0]            running_sum, running_sum_next;
  logic [31:0]            data_start, data_start_next;
  logic [1:0]             first_error, first_error_next;

  // Result queue
  res_t               rq [RQ_DEPTH];
  logic [PTR_W-1:0]   head, tail, tail_p1;
  logic [CNT_W-1:0]   count;

  logic       in_acc, out_acc;
  logic [7:0] b;
  logic [15:0] word;
  logic [3:0] sub_e;
  logic       sat, at_extra_last;
  logic       fail_req, tdone, leave;
  logic [1:0] fail_code;
  phase_t     leave_from;
  logic       chunk_push;
  res_t       chunk_res, sum_res;
  logic [1:0] push_n;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign b       = in_ch.file_byte;
  assign word    = {b, low_byte_latch};
  assign sub_e   = 4'(byte_position[4:0] - 5'(FIXED_LEN));
  assign sat     = (byte_position == '1);
  assign at_extra_last = (CW'(byte_position) == CW'(extra_last));

  always_comb begin
    byte_position_next    = byte_position;
    data_count_next       = data_count;
    phase_next            = phase;
    header_flags_next     = header_flags;
    extra_length_next     = extra_length;
    extra_last_next       = extra_last;
    low_byte_latch_next   = low_byte_latch;
    length_per_chunk_next = length_per_chunk;
    declared_chunks_next  = declared_chunks;
    chunks_seen_next      = chunks_seen;
    running_sum_next      = running_sum;
    data_start_next       = data_start;
    first_error_next      = first_error;
    fail_req   = 1'b0;
    fail_code  = ST_OK;
    tdone      = 1'b0;
    leave      = 1'b0;
    leave_from = PH_SKIP;
    chunk_push = 1'b0;
    chunk_res  = '0;
    sum_res    = '0;

    if (sat) begin
      // counter has stopped: drop the byte and flag it
      fail_req  = 1'b1;
      fail_code = ST_BAD;
    end else begin
      byte_position_next = byte_position + OFFSET_BITS'(1);
      case (phase)
        PH_FIXED: begin
          case (byte_position[3:0])
            POS_ID1: if (b != GZ_ID1) begin fail_req = 1'b1; fail_code = ST_NOT_DZ; end
            POS_ID2: if (b != GZ_ID2) begin fail_req = 1'b1; fail_code = ST_NOT_DZ; end
            POS_CM:  if (b != GZ_CM_DEFL) begin fail_req = 1'b1; fail_code = ST_NOT_DZ; end
            POS_FLG: begin
              header_flags_next = b;
              if (!b[FLG_EXTRA]) begin fail_req = 1'b1; fail_code = ST_BAD; end
            end
            POS_XLEN0: low_byte_latch_next = b;
            POS_XLEN1: begin
              extra_length_next = word;
              extra_last_next   = 17'(word) + 17'(POS_XLEN1);
              if (word == 16'd0) begin
                fail_req  = 1'b1;
                fail_code = ST_BAD;
              end else begin
                phase_next = PH_SUB;
              end
            end
            default: ;
          endcase
        end
        PH_SUB: begin
          case (sub_e)
            SUB_SI1: if (b != RA_SI1) begin fail_req = 1'b1; fail_code = ST_BAD; end
            SUB_SI2: if (b != RA_SI2) begin fail_req = 1'b1; fail_code = ST_BAD; end
            SUB_LEN: begin
              if (extra_length < RA_HDR_LEN || word != (extra_length - RA_HDR_LEN)) begin
                fail_req  = 1'b1;
                fail_code = ST_BAD;
              end
            end
            SUB_VER: if (word != RA_VERSION) begin fail_req = 1'b1; fail_code = ST_BAD; end
            SUB_CLEN: length_per_chunk_next = word;
            SUB_CCNT: begin
              declared_chunks_next = word;
              if (word == 16'd0) tdone = 1'b1;
              else phase_next = PH_TABLE;
            end
            default: low_byte_latch_next = b;  // even offsets: low byte of a word
          endcase
        end
        PH_TABLE: begin
          if (!byte_position[0]) begin
            low_byte_latch_next = b;
          end else begin
            chunk_push             = 1'b1;
            chunk_res.chunk_index  = chunks_seen;
            chunk_res.chunk_start  = running_sum;
            chunk_res.chunk_span   = length_per_chunk;
            chunk_res.chunk_total  = declared_chunks;
            running_sum_next = running_sum + 32'(word);
            chunks_seen_next = chunks_seen + 16'd1;
            if (chunks_seen_next == declared_chunks) tdone = 1'b1;
          end
        end
        PH_SKIP: begin
          if (at_extra_last) leave = 1'b1;
        end
        PH_NAME, PH_COMMENT: begin
          if (b == 8'd0) begin
            leave      = 1'b1;
            leave_from = phase;
          end
        end
        PH_CRC1: phase_next = PH_CRC2;
        PH_CRC2: begin
          leave      = 1'b1;
          leave_from = PH_CRC2;
        end
        PH_DATA: data_count_next = data_count + OFFSET_BITS'(1);
        default: ;
      endcase

      // table finished: leave at once if the extra field ends here, else skip the rest
      if (tdone) begin
        if (at_extra_last) leave = 1'b1;
        else phase_next = PH_SKIP;
      end
      if (leave) begin
        phase_next = leave_next(leave_from, header_flags);
        if (phase_next == PH_DATA) begin
          data_start_next = 32'(byte_position_next);
          data_count_next = '0;
        end
      end
      // subfield or table still open at the last byte of the extra field
      if (!fail_req && (phase == PH_SUB || phase == PH_TABLE) &&
          (phase_next == PH_SUB || phase_next == PH_TABLE) && at_extra_last) begin
        fail_req  = 1'b1;
        fail_code = ST_BAD;
      end
    end

    if (fail_req) begin
      if (first_error == ST_OK) first_error_next = fail_code;
      phase_next = PH_FAILED;
    end

    sum_res.is_summary  = 1'b1;
    sum_res.chunk_span  = length_per_chunk_next;
    sum_res.chunk_total = declared_chunks_next;
    if (byte_position_next < OFFSET_BITS'(FIXED_LEN)) begin
      sum_res.status = ST_NOT_DZ;
    end else if (first_error_next != ST_OK) begin
      sum_res.status = first_error_next;
    end else if (phase_next != PH_DATA || data_count_next == '0) begin
      sum_res.status = ST_BAD;
    end else if (CW'(running_sum_next) > CW'(data_count_next)) begin
      sum_res.status = ST_BAD;
    end else begin
      sum_res.status     = ST_OK;
      sum_res.data_begin = data_start_next;
      sum_res.end_offset = data_start_next + running_sum_next;
    end

    // summary ends the run: return to reset values
    if (in_ch.last_byte) begin
      byte_position_next    = '0;
      data_count_next       = '0;
      phase_next            = PH_FIXED;
      header_flags_next     = '0;
      extra_length_next     = '0;
      extra_last_next       = 17'(POS_XLEN1);
      low_byte_latch_next   = '0;
      length_per_chunk_next = '0;
      declared_chunks_next  = '0;
      chunks_seen_next      = '0;
      running_sum_next      = '0;
      data_start_next       = '0;
      first_error_next      = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      data_count       <= '0;
      phase            <= PH_FIXED;
      header_flags     <= '0;
      extra_length     <= '0;
      extra_last       <= 17'(POS_XLEN1);
      low_byte_latch   <= '0;
      length_per_chunk <= '0;
      declared_chunks  <= '0;
      chunks_seen      <= '0;
      running_sum      <= '0;
      data_start       <= '0;
      first_error      <= ST_OK;
    end else if (in_acc) begin
      byte_position    <= byte_position_next;
      data_count       <= data_count_next;
      phase            <= phase_next;
      header_flags     <= header_flags_next;
      extra_length     <= extra_length_next;
      extra_last       <= extra_last_next;
      low_byte_latch   <= low_byte_latch_next;
      length_per_chunk <= length_per_chunk_next;
      declared_chunks  <= declared_chunks_next;
      chunks_seen      <= chunks_seen_next;
      running_sum      <= running_sum_next;
      data_start       <= data_start_next;
      first_error      <= first_error_next;
    end
  end

  // Result queue: up to two writes per accepted byte, one read per transaction
  assign tail_p1 = tail + PTR_W'(1);
  assign push_n  = in_acc ? (2'(chunk_push) + 2'(in_ch.last_byte)) : 2'd0;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (chunk_push) begin
        rq[tail] <= chunk_res;
        if (in_ch.last_byte) rq[tail_p1] <= sum_res;
      end else if (in_ch.last_byte) begin
        rq[tail] <= sum_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + PTR_W'(push_n);
      if (out_acc) head <= head + PTR_W'(1);
      count <= count + CNT_W'(push_n) - CNT_W'(out_acc);
    end
  end

  assign in_ch.ready        = (count <= CNT_W'(RQ_DEPTH - 2));
  assign out_ch.valid       = (count != '0);
  assign out_ch.is_summary  = rq[head].is_summary;
  assign out_ch.chunk_index = rq[head].chunk_index;
  assign out_ch.chunk_start = rq[head].chunk_start;
  assign out_ch.status      = rq[head].status;
  assign out_ch.data_begin  = rq[head].data_begin;
  assign out_ch.chunk_span  = rq[head].chunk_span;
  assign out_ch.chunk_total = rq[head].chunk_total;
  assign out_ch.end_offset  = rq[head].end_offset;

  // Checks
  a_restart: assert property (@(posedge clk) disable iff (rst)
    in_acc && in_ch.last_byte |=> (phase == PH_FIXED && byte_position == '0))
    else $error("parser did not return to the start after a summary");

  a_two_push: assert property (@(posedge clk) disable iff (rst)
    (push_n == 2'd2) |-> (phase == PH_TABLE && in_ch.last_byte))
    else $error("double result outside a final table word");

  a_table_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_TABLE) |-> (chunks_seen < declared_chunks))
    else $error("chunk table walked past the declared count");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (count > CNT_W'(RQ_DEPTH - 2)) |=> (count <= CNT_W'(RQ_DEPTH)))
    else $error("result queue overflow");

endmodule

`default_nettype wire

// ===== dv/dzhp_result_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the dictzip header parser: follows the header walk on every
// byte transaction and compares each result transaction with its prediction.
// Depends on dzhp_pkg, dzhp_in_if and dzhp_out_if.
module dzhp_result_checker
  import dzhp_pkg::*;
(
  input  wire clk,
  input  wire rst,
  dzhp_in_if  in_ch,
  dzhp_out_if out_ch,
  output int  mismatches,
  output int  outstanding
);

  localparam logic [63:0] POS_LIMIT = (64'd1 << OFFSET_BITS_DEF) - 64'd1;
  localparam int REPORT_LIMIT = 10;

  res_t        expected_results[$];
  logic [63:0] byte_pos;
  phase_t      phase;
  logic [7:0]  hdr_flags;
  logic [15:0] xlen;
  logic [7:0]  lo_latch;
  logic [15:0] span_latch;
  logic [15:0] chunk_cnt;
  logic [15:0] chunks_done;
  logic [31:0] size_sum;
  logic [63:0] data_base;
  logic [1:0]  err_code;
  int          error_total;

  task automatic clear_walk();
    byte_pos    = '0;
    phase       = PH_FIXED;
    hdr_flags   = '0;
    xlen        = '0;
    lo_latch    = '0;
    span_latch  = '0;
    chunk_cnt   = '0;
    chunks_done = '0;
    size_sum    = '0;
    data_base   = '0;
    err_code    = ST_OK;
  endtask

  // Keep the first fault; everything after it is ignored until the final byte
  task automatic flag_error(input logic [1:0] code);
    if (err_code == ST_OK) err_code = code;
    phase = PH_FAILED;
  endtask

  task automatic advance_section(input phase_t done, input logic [63:0] p);
    phase_t nx;
    nx = PH_DATA;
    if (done == PH_SKIP && hdr_flags[FLG_NAME]) nx = PH_NAME;
    else if ((done == PH_SKIP || done == PH_NAME) && hdr_flags[FLG_COMM]) nx = PH_COMMENT;
    else if ((done == PH_SKIP || done == PH_NAME || done == PH_COMMENT) &&
             hdr_flags[FLG_HCRC]) nx = PH_CRC1;
    phase = nx;
    if (nx == PH_DATA) data_base = p + 64'd1;
  endtask

  // Skip whatever is left of the extra field once the table is complete
  task automatic table_finished(input logic [63:0] p);
    if (p == 64'd11 + xlen) advance_section(PH_SKIP, p);
    else phase = PH_SKIP;
  endtask

  task automatic walk_byte(input logic [7:0] b, input logic fin);
    logic [63:0] p;
    logic [63:0] extra_end;
    logic [63:0] e;
    logic [15:0] word;
    logic [1:0]  st;
    logic [63:0] doff;
    logic [63:0] eoff;
    res_t        r;
    if (byte_pos >= POS_LIMIT) begin
      flag_error(ST_BAD);
    end else begin
      p = byte_pos;
      byte_pos = p + 64'd1;
      extra_end = 64'd11 + xlen;
      word = {b, lo_latch};
      case (phase)
        PH_FIXED: begin
          if (p == POS_ID1 && b != GZ_ID1) flag_error(ST_NOT_DZ);
          else if (p == POS_ID2 && b != GZ_ID2) flag_error(ST_NOT_DZ);
          else if (p == POS_CM && b != GZ_CM_DEFL) flag_error(ST_NOT_DZ);
          else if (p == POS_FLG) begin
            hdr_flags = b;
            if (!b[FLG_EXTRA]) flag_error(ST_BAD);
          end else if (p == POS_XLEN0) lo_latch = b;
          else if (p == POS_XLEN1) begin
            xlen = {b, lo_latch};
            if (xlen == 16'd0) flag_error(ST_BAD);
            else phase = PH_SUB;
          end
        end
        PH_SUB: begin
          e = p - FIXED_LEN;
          if (e == SUB_SI1) begin
            if (b != RA_SI1) flag_error(ST_BAD);
          end else if (e == SUB_SI2) begin
            if (b != RA_SI2) flag_error(ST_BAD);
          end else if (!e[0]) lo_latch = b;
          else if (e == SUB_LEN) begin
            if (xlen < RA_HDR_LEN || word != xlen - RA_HDR_LEN) flag_error(ST_BAD);
          end else if (e == SUB_VER) begin
            if (word != RA_VERSION) flag_error(ST_BAD);
          end else if (e == SUB_CLEN) span_latch = word;
          else if (e == SUB_CCNT) begin
            chunk_cnt = word;
            if (word == 16'd0) table_finished(p);
            else phase = PH_TABLE;
          end
          if ((phase == PH_SUB || phase == PH_TABLE) && p == extra_end) flag_error(ST_BAD);
        end
        PH_TABLE: begin
          // table words start at an even position
          if (!p[0]) begin
            lo_latch = b;
          end else begin
            r = {1'b0, chunks_done, size_sum, ST_OK, 32'd0, span_latch, chunk_cnt, 32'd0};
            expected_results.push_back(r);
            size_sum = size_sum + {16'd0, word};
            chunks_done = chunks_done + 16'd1;
            if (chunks_done == chunk_cnt) table_finished(p);
          end
          if ((phase == PH_SUB || phase == PH_TABLE) && p == extra_end) flag_error(ST_BAD);
        end
        PH_SKIP: begin
          if (p == extra_end) advance_section(PH_SKIP, p);
        end
        PH_NAME, PH_COMMENT: begin
          if (b == 8'd0) advance_section(phase, p);
        end
        PH_CRC1: phase = PH_CRC2;
        PH_CRC2: advance_section(PH_CRC2, p);
        default: ;
      endcase
    end

    if (fin) begin
      doff = '0;
      eoff = '0;
      if (byte_pos < FIXED_LEN) st = ST_NOT_DZ;
      else if (err_code != ST_OK) st = err_code;
      else if (phase != PH_DATA || data_base >= byte_pos) st = ST_BAD;
      else if ({32'd0, size_sum} > byte_pos - data_base) st = ST_BAD;
      else begin
        st = ST_OK;
        doff = data_base;
        eoff = data_base + {32'd0, size_sum};
      end
      r = {1'b1, 16'd0, 32'd0, st, doff[31:0], span_latch, chunk_cnt, eoff[31:0]};
      expected_results.push_back(r);
      clear_walk();
    end
  endtask

  function automatic string show_result(input res_t r);
    return $sformatf({"summary=%0d index=%0d start=%0h status=%0d ",
                      "data=%0h clen=%0h cnt=%0h end=%0h"},
                     r.is_summary, r.chunk_index, r.chunk_start, r.status, r.data_begin,
                     r.chunk_span, r.chunk_total, r.end_offset);
  endfunction

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst) begin
      clear_walk();
      expected_results.delete();
      error_total = 0;
    end else begin
      // Results pass through the queue registers first, so compare before predicting
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.is_summary, out_ch.chunk_index, out_ch.chunk_start, out_ch.status,
               out_ch.data_begin, out_ch.chunk_span, out_ch.chunk_total,
               out_ch.end_offset};
        if (expected_results.size() == 0) begin
          if (error_total < REPORT_LIMIT)
            $display("%0t: result with nothing pending: %s", $time, show_result(got));
          error_total++;
        end else begin
          want = expected_results.pop_front();
          if (got.is_summary !== want.is_summary || got.chunk_index !== want.chunk_index ||
              got.chunk_start !== want.chunk_start || got.status !== want.status ||
              got.data_begin !== want.data_begin ||
              got.chunk_span !== want.chunk_span ||
              got.chunk_total !== want.chunk_total || got.end_offset !== want.end_offset) begin
            if (error_total < REPORT_LIMIT) begin
              $display("%0t: result mismatch", $time);
              $display("  expected %s", show_result(want));
              $display("  actual   %s", show_result(got));
            end
            error_total++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) walk_byte(in_ch.file_byte, in_ch.last_byte);
    end
    mismatches  <= error_total;
    outstanding <= expected_results.size();
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Top of the dictzip header parser bench: clock, reset, file stimulus and verdict.
// Depends on dzhp_pkg, both channel interfaces, the parser and dzhp_result_checker.
module testbench;
  import dzhp_pkg::*;

  localparam int RANDOM_BYTES   = 800;
  localparam int CALM_FROM      = 650;
  localparam int HOLD_AT        = 300;
  localparam int HOLD_CYCLES    = 48;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef enum int {
    FILE_GOOD, FILE_SHORT, FILE_BAD_MAGIC, FILE_BAD_METHOD, FILE_NO_EXTRA, FILE_XLEN_ZERO,
    FILE_XLEN_TINY, FILE_BAD_ID, FILE_BAD_LEN, FILE_BAD_VER, FILE_TABLE_PAST,
    FILE_TRUNCATED, FILE_NO_DATA, FILE_OVERRUN, FILE_NOISE
  } file_kind_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic [7:0] file_bytes[$];
  int         bytes_sent = 0;
  int         idle_pct = 0;
  bit         calm = 1'b0;
  bit         hold_done = 1'b0;
  int         mismatches;
  int         outstanding;
  int         quiet_cycles = 0;

  dzhp_in_if  byte_ch ();
  dzhp_out_if result_ch ();

  dictzip_header_parser_top dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (byte_ch),
    .out_ch (result_ch)
  );

  dzhp_result_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (byte_ch),
    .out_ch      (result_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #6 clk = ~clk;

  // Build one file of the given kind: well-formed dictzip plus its fault, or noise
  task automatic make_file(input file_kind_t kind);
    int          cnt;
    int          pad;
    int          xlen;
    int          sum;
    int          data_len;
    int          hdr_end;
    int          keep;
    int          idx;
    logic [7:0]  flags;
    logic [15:0] clen;
    logic [15:0] size;
    logic [15:0] sub_len;
    file_bytes.delete();
    if (kind == FILE_NOISE) begin
      repeat ($urandom_range(1, 24)) file_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    cnt = $urandom_range(0, 3);
    if (kind == FILE_OVERRUN && cnt == 0) cnt = 1;
    pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    xlen = 10 + 2 * cnt + pad;
    if (kind == FILE_TABLE_PAST) begin
      pad = 0;
      xlen = 10 + 2 * cnt - $urandom_range(1, 2 * cnt + 6);
    end
    if (kind == FILE_XLEN_TINY) xlen = $urandom_range(1, 3);
    if (kind == FILE_XLEN_ZERO) xlen = 0;
    sub_len = 16'(xlen - 4);
    flags = 8'($urandom_range(0, 255)) | 8'h04;
    case ($urandom_range(0, 3))
      0: clen = 16'h0000;
      1: clen = 16'hffff;
      default: clen = 16'($urandom_range(0, 65535));
    endcase

    file_bytes.push_back(GZ_ID1);
    file_bytes.push_back(GZ_ID2);
    file_bytes.push_back(GZ_CM_DEFL);
    file_bytes.push_back(flags);
    repeat (6) file_bytes.push_back(8'($urandom_range(0, 255)));
    file_bytes.push_back(xlen[7:0]);
    file_bytes.push_back(xlen[15:8]);
    file_bytes.push_back(RA_SI1);
    file_bytes.push_back(RA_SI2);
    file_bytes.push_back(sub_len[7:0]);
    file_bytes.push_back(sub_len[15:8]);
    file_bytes.push_back(RA_VERSION[7:0]);
    file_bytes.push_back(RA_VERSION[15:8]);
    file_bytes.push_back(clen[7:0]);
    file_bytes.push_back(clen[15:8]);
    file_bytes.push_back(8'(cnt));
    file_bytes.push_back(8'(cnt >> 8));
    sum = 0;
    repeat (cnt) begin
      if (kind == FILE_OVERRUN && $urandom_range(0, 1) == 1) size = 16'($urandom_range(1, 65535));
      else if (kind == FILE_OVERRUN) size = 16'($urandom_range(1, 6));
      else size = 16'($urandom_range(0, 6));
      file_bytes.push_back(size[7:0]);
      file_bytes.push_back(size[15:8]);
      sum += size;
    end
    repeat (pad) file_bytes.push_back(8'($urandom_range(0, 255)));
    if (flags[FLG_NAME]) begin
      repeat ($urandom_range(0, 4)) file_bytes.push_back(8'($urandom_range(1, 255)));
      file_bytes.push_back(8'h00);
    end
    if (flags[FLG_COMM]) begin
      repeat ($urandom_range(0, 4)) file_bytes.push_back(8'($urandom_range(1, 255)));
      file_bytes.push_back(8'h00);
    end
    if (flags[FLG_HCRC]) repeat (2) file_bytes.push_back(8'($urandom_range(0, 255)));
    hdr_end = file_bytes.size();

    if (kind == FILE_GOOD) begin
      data_len = sum + $urandom_range(0, 3);
      if (data_len == 0) data_len = 1;
    end else if (kind == FILE_NO_DATA) data_len = 0;
    else if (kind == FILE_OVERRUN) data_len = $urandom_range(0, (sum - 1 < 8) ? sum - 1 : 8);
    else data_len = $urandom_range(1, 4);
    repeat (data_len) file_bytes.push_back(8'($urandom_range(0, 255)));

    case (kind)
      FILE_BAD_MAGIC: begin
        idx = $urandom_range(0, 1);
        file_bytes[idx] = file_bytes[idx] ^ 8'($urandom_range(1, 255));
      end
      FILE_BAD_METHOD: file_bytes[2] = file_bytes[2] ^ 8'($urandom_range(1, 255));
      FILE_NO_EXTRA:   file_bytes[3][FLG_EXTRA] = 1'b0;
      FILE_BAD_ID: begin
        idx = $urandom_range(12, 13);
        file_bytes[idx] = file_bytes[idx] ^ 8'($urandom_range(1, 255));
      end
      FILE_BAD_LEN: begin
        idx = $urandom_range(14, 15);
        file_bytes[idx] = file_bytes[idx] ^ 8'($urandom_range(1, 255));
      end
      FILE_BAD_VER: begin
        idx = $urandom_range(16, 17);
        file_bytes[idx] = file_bytes[idx] ^ 8'($urandom_range(1, 255));
      end
      FILE_TRUNCATED: begin
        keep = $urandom_range(12, hdr_end);
        while (file_bytes.size() > keep) void'(file_bytes.pop_back());
      end
      FILE_SHORT: begin
        keep = $urandom_range(1, 11);
        while (file_bytes.size() > keep) void'(file_bytes.pop_back());
      end
      default: ;
    endcase
  endtask

  // Offer one byte transaction, with an occasional idle burst in front of it
  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (!calm && idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.file_byte <= b;
    byte_ch.last_byte <= fin;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_file();
    case ($urandom_range(0, 2))
      0: idle_pct = 0;
      1: idle_pct = 15;
      default: idle_pct = 40;
    endcase
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
  endtask

  initial begin
    byte_ch.valid     = 1'b0;
    byte_ch.file_byte = 8'h00;
    byte_ch.last_byte = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Single-byte file, then the smallest valid file with an empty table
    file_bytes = '{8'hff};
    send_file();
    file_bytes = '{GZ_ID1, GZ_ID2, GZ_CM_DEFL, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                   8'hff, 8'd10, 8'd0, RA_SI1, RA_SI2, 8'd6, 8'd0, 8'd1, 8'd0, 8'hff,
                   8'hff, 8'd0, 8'd0, 8'h5a};
    send_file();

    while (bytes_sent < RANDOM_BYTES) begin
      if (bytes_sent >= CALM_FROM) calm = 1'b1;
      if ($urandom_range(0, 99) < 40) make_file(FILE_GOOD);
      else make_file(file_kind_t'($urandom_range(FILE_SHORT, FILE_NOISE)));
      send_file();
    end
    byte_ch.valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // Result side: random stall bursts and one long hold-off to back up the input
  initial begin
    result_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!hold_done && bytes_sent >= HOLD_AT) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ===== sim.f =====
rtl/dzhp_pkg.sv
rtl/dzhp_in_if.sv
rtl/dzhp_out_if.sv
rtl/dictzip_header_parser_top.sv
dv/dzhp_result_checker.sv
dv/testbench.sv
